// File: design/lwcs_pkg.sv
// Shared package for the LCD window command serializer.
// Holds field widths, function and opcode constants, sequence slots and the structs
// passed between the decode stage, the byte sequencer and the top level.
package lwcs_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 2;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 4;

    // Request functions.
    localparam logic [FUNC_W-1:0] FUNC_PIXEL  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLIP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STRICT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COLOR  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd5;

    // Controller opcodes.
    localparam logic [BYTE_W-1:0] OP_COLSET   = 8'h2A;
    localparam logic [BYTE_W-1:0] OP_ROWSET   = 8'h2B;
    localparam logic [BYTE_W-1:0] OP_MEMWRITE = 8'h2C;
    localparam logic [BYTE_W-1:0] OP_INV_OFF  = 8'h20;
    localparam logic [BYTE_W-1:0] OP_INV_ON   = 8'h21;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OFFSET_X      = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y      = 2'd3;

    // Register reset values.
    localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 16'd128;
    localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 16'd160;
    localparam logic [COORD_W-1:0] RST_OFFSET_X      = 16'd1;
    localparam logic [COORD_W-1:0] RST_OFFSET_Y      = 16'd2;

    // Byte slots of the window and pixel sequence.
    localparam logic [IDX_W-1:0] IDX_COLSET   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_X1_HI    = 4'd1;
    localparam logic [IDX_W-1:0] IDX_X1_LO    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_X2_HI    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_X2_LO    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_ROWSET   = 4'd5;
    localparam logic [IDX_W-1:0] IDX_Y1_HI    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_Y1_LO    = 4'd7;
    localparam logic [IDX_W-1:0] IDX_Y2_HI    = 4'd8;
    localparam logic [IDX_W-1:0] IDX_Y2_LO    = 4'd9;
    localparam logic [IDX_W-1:0] IDX_MEMWRITE = 4'd10;
    localparam logic [IDX_W-1:0] IDX_COLOR_HI = 4'd11;
    localparam logic [IDX_W-1:0] IDX_COLOR_LO = 4'd12;

    // Kind of byte sequence a decoded request produces.
    typedef enum logic [2:0] {
        JOB_STATUS,
        JOB_CMD,
        JOB_PAIR,
        JOB_WINDOW,
        JOB_PIXEL
    } job_kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] off_y;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] color;
        logic               enable;
    } item_t;

    typedef struct packed {
        job_kind_t          kind;
        logic               accepted;
        logic               sel;
        logic [BYTE_W-1:0]  cmd;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [COORD_W-1:0] color;
    } job_t;

endpackage

// File: design/lwcs_decode.sv
// Request decode for the LCD window command serializer.
// Runs bounds checks and clipping on one registered request and builds a job.
// Depends on lwcs_pkg.
module lwcs_decode (
    input  lwcs_pkg::item_t cfg_item,
    input  lwcs_pkg::cfg_t  cfg,
    input  logic            window_open,
    output lwcs_pkg::job_t  job,
    output logic            window_open_next
);

    logic                         off_panel;
    logic [lwcs_pkg::COORD_W:0]   sum_x;
    logic [lwcs_pkg::COORD_W:0]   sum_y;
    logic                         over_x;
    logic                         over_y;
    logic [lwcs_pkg::COORD_W-1:0] fit_x;
    logic [lwcs_pkg::COORD_W-1:0] fit_y;
    logic [lwcs_pkg::COORD_W-1:0] edge_x;
    logic [lwcs_pkg::COORD_W-1:0] edge_y;

    // Bounds tests and the far corner of a window before offsets.
    always_comb begin
        off_panel = (cfg_item.x >= cfg.width) || (cfg_item.y >= cfg.height);
        sum_x  = {1'b0, cfg_item.x} + {1'b0, cfg_item.width};
        sum_y  = {1'b0, cfg_item.y} + {1'b0, cfg_item.height};
        over_x = sum_x > {1'b0, cfg.width};
        over_y = sum_y > {1'b0, cfg.height};
        fit_x  = sum_x[lwcs_pkg::COORD_W-1:0] - 16'd1;
        fit_y  = sum_y[lwcs_pkg::COORD_W-1:0] - 16'd1;
        // A clipped edge ends on the last column or row of the panel.
        edge_x = over_x ? (cfg.width - 16'd1) : fit_x;
        edge_y = over_y ? (cfg.height - 16'd1) : fit_y;
    end

    // Select the job; rejected requests fall through as a status result.
    always_comb begin
        job.kind         = lwcs_pkg::JOB_STATUS;
        job.accepted     = 1'b0;
        job.sel          = window_open;
        job.cmd          = lwcs_pkg::OP_INV_OFF;
        job.x1           = cfg_item.x;
        job.y1           = cfg_item.y;
        job.x2           = fit_x;
        job.y2           = fit_y;
        job.color        = cfg_item.color;
        window_open_next = window_open;
        unique case (cfg_item.func)
            lwcs_pkg::FUNC_PIXEL: begin
                if (!off_panel) begin
                    job.kind         = lwcs_pkg::JOB_PIXEL;
                    job.accepted     = 1'b1;
                    job.x2           = cfg_item.x + 16'd1;
                    job.y2           = cfg_item.y + 16'd1;
                    window_open_next = 1'b0;
                end
            end
            lwcs_pkg::FUNC_CLIP: begin
                if (!off_panel) begin
                    job.kind         = lwcs_pkg::JOB_WINDOW;
                    job.accepted     = 1'b1;
                    job.x2           = edge_x;
                    job.y2           = edge_y;
                    window_open_next = 1'b1;
                end
            end
            lwcs_pkg::FUNC_STRICT: begin
                if (!off_panel && !over_x && !over_y) begin
                    job.kind         = lwcs_pkg::JOB_WINDOW;
                    job.accepted     = 1'b1;
                    window_open_next = 1'b1;
                end
            end
            lwcs_pkg::FUNC_COLOR: begin
                if (window_open) begin
                    job.kind     = lwcs_pkg::JOB_PAIR;
                    job.accepted = 1'b1;
                end
            end
            lwcs_pkg::FUNC_CLOSE: begin
                job.accepted     = 1'b1;
                job.sel          = 1'b0;
                window_open_next = 1'b0;
            end
            lwcs_pkg::FUNC_INVERT: begin
                job.kind         = lwcs_pkg::JOB_CMD;
                job.accepted     = 1'b1;
                job.cmd          = cfg_item.enable ? lwcs_pkg::OP_INV_ON : lwcs_pkg::OP_INV_OFF;
                window_open_next = 1'b0;
            end
            default: begin
                job.accepted = 1'b0;
            end
        endcase
    end

endmodule

// File: design/lwcs_emit.sv
// Byte sequencer of the LCD window command serializer.
// Holds one decoded job, steps through its byte slots and drives the result register.
// Depends on lwcs_pkg.
module lwcs_emit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  lwcs_pkg::job_t                   job,
    input  lwcs_pkg::cfg_t                   cfg,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lwcs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [lwcs_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);

    lwcs_pkg::job_t              job_reg;
    logic                        busy_reg;
    logic                        busy_next;
    logic [lwcs_pkg::IDX_W-1:0]  idx_reg;
    logic [lwcs_pkg::IDX_W-1:0]  idx_next;
    logic [lwcs_pkg::IDX_W-1:0]  end_idx;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [lwcs_pkg::BYTE_W-1:0] byte_reg;
    logic                        has_reg;
    logic                        data_reg;
    logic                        sel_reg;
    logic                        acc_reg;
    logic                        last_reg;

    logic                         is_end;
    logic                         out_adv;
    logic                         step;
    logic                         load;
    logic [lwcs_pkg::COORD_W-1:0] word;
    logic [lwcs_pkg::COORD_W-1:0] offs;
    logic [lwcs_pkg::COORD_W-1:0] coord;
    logic                         hi;
    logic                         is_cmd;
    logic [lwcs_pkg::BYTE_W-1:0]  slot_cmd;
    logic [lwcs_pkg::BYTE_W-1:0]  byte_c;
    logic                         has_c;
    logic                         data_c;
    logic                         sel_c;
    logic                         acc_c;
    logic                         last_c;

    // Final slot of the current job.
    always_comb begin
        unique case (job_reg.kind)
            lwcs_pkg::JOB_WINDOW: end_idx = lwcs_pkg::IDX_MEMWRITE;
            lwcs_pkg::JOB_PIXEL:  end_idx = lwcs_pkg::IDX_COLOR_LO;
            lwcs_pkg::JOB_PAIR:   end_idx = lwcs_pkg::IDX_COLOR_LO;
            default:              end_idx = lwcs_pkg::IDX_COLSET;
        endcase
    end

    // Handshake: a new job may load in the cycle the last byte moves out.
    assign is_end    = idx_reg == end_idx;
    assign out_adv   = !m_valid_reg || m_tready;
    assign step      = busy_reg && out_adv;
    assign job_ready = !busy_reg || (step && is_end);
    assign load      = job_valid && job_ready;

    // Pick the word, offset and byte half of the current slot.
    always_comb begin
        word     = job_reg.color;
        offs     = '0;
        hi       = 1'b1;
        is_cmd   = 1'b0;
        slot_cmd = lwcs_pkg::OP_COLSET;
        unique case (idx_reg)
            lwcs_pkg::IDX_COLSET: begin
                is_cmd = 1'b1;
            end
            lwcs_pkg::IDX_X1_HI: begin
                word = job_reg.x1;
                offs = cfg.off_x;
            end
            lwcs_pkg::IDX_X1_LO: begin
                word = job_reg.x1;
                offs = cfg.off_x;
                hi   = 1'b0;
            end
            lwcs_pkg::IDX_X2_HI: begin
                word = job_reg.x2;
                offs = cfg.off_x;
            end
            lwcs_pkg::IDX_X2_LO: begin
                word = job_reg.x2;
                offs = cfg.off_x;
                hi   = 1'b0;
            end
            lwcs_pkg::IDX_ROWSET: begin
                is_cmd   = 1'b1;
                slot_cmd = lwcs_pkg::OP_ROWSET;
            end
            lwcs_pkg::IDX_Y1_HI: begin
                word = job_reg.y1;
                offs = cfg.off_y;
            end
            lwcs_pkg::IDX_Y1_LO: begin
                word = job_reg.y1;
                offs = cfg.off_y;
                hi   = 1'b0;
            end
            lwcs_pkg::IDX_Y2_HI: begin
                word = job_reg.y2;
                offs = cfg.off_y;
            end
            lwcs_pkg::IDX_Y2_LO: begin
                word = job_reg.y2;
                offs = cfg.off_y;
                hi   = 1'b0;
            end
            lwcs_pkg::IDX_MEMWRITE: begin
                is_cmd   = 1'b1;
                slot_cmd = lwcs_pkg::OP_MEMWRITE;
            end
            lwcs_pkg::IDX_COLOR_HI: begin
                hi = 1'b1;
            end
            lwcs_pkg::IDX_COLOR_LO: begin
                hi = 1'b0;
            end
            default: begin
                hi = 1'b1;
            end
        endcase
        coord = word + offs;
    end

    // Build the result fields for the current slot.
    always_comb begin
        byte_c = '0;
        has_c  = 1'b1;
        data_c = 1'b0;
        sel_c  = 1'b1;
        acc_c  = 1'b1;
        last_c = 1'b1;
        unique case (job_reg.kind)
            lwcs_pkg::JOB_STATUS: begin
                has_c = 1'b0;
                sel_c = job_reg.sel;
                acc_c = job_reg.accepted;
            end
            lwcs_pkg::JOB_CMD: begin
                byte_c = job_reg.cmd;
                sel_c  = 1'b0;
            end
            lwcs_pkg::JOB_PAIR, lwcs_pkg::JOB_WINDOW, lwcs_pkg::JOB_PIXEL: begin
                if (is_cmd) begin
                    byte_c = slot_cmd;
                end else begin
                    byte_c = hi ? coord[15:8] : coord[7:0];
                end
                data_c = !is_cmd;
                // A pixel releases chip select after its last color byte.
                sel_c  = !((job_reg.kind == lwcs_pkg::JOB_PIXEL) && is_end);
                last_c = is_end;
            end
            default: begin
                has_c = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer and the result register.
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = (job.kind == lwcs_pkg::JOB_PAIR) ? lwcs_pkg::IDX_COLOR_HI
                                                          : lwcs_pkg::IDX_COLSET;
        end else if (step) begin
            busy_next = !is_end;
            idx_next  = idx_reg + 4'd1;
        end
        m_valid_next = out_adv ? busy_reg : m_valid_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job;
        end
        if (step) begin
            byte_reg <= byte_c;
            has_reg  <= has_c;
            data_reg <= data_c;
            sel_reg  <= sel_c;
            acc_reg  <= acc_c;
            last_reg <= last_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, acc_reg, sel_reg, byte_reg};
    assign m_tuser  = {data_reg, has_reg};
    assign m_tlast  = last_reg;

endmodule

// File: design/lcd_window_command_serializer_top.sv
// Top level of the LCD window command serializer.
// Holds the APB registers, the request register and the window state; uses
// lwcs_pkg, lwcs_decode and lwcs_emit.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  s_       | in        | s_tvalid / s_tready      | s_tdata, s_tuser (request)
//  m_       | out       | m_tvalid / m_tready      | m_tdata, m_tuser, m_tlast
//  APB      | in        | psel / penable / pready  | paddr, pwdata, prdata
//
// A request is decoded in the request register and then occupies the byte
// sequencer for one cycle per result while m_ does not stall: 1 result for
// status, close and invert, 2 for a color, 11 for a window, 13 for a pixel.
// The next request is decoded while the last byte of the previous one moves
// out, so results stream without gaps. A request passes through the request
// register, the sequencer job register and the result register.
// Reset is synchronous and active low; it restores register defaults and
// closes the window. A stall on m_ holds the result register and backs up
// into the sequencer and then the request register.
module lcd_window_command_serializer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: x[15:0], y[31:16], width[47:32], height[63:48], color[79:64],
    // enable[80], zero fill up to 87
    input  logic [lwcs_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: func[2:0]
    input  logic [lwcs_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: byte_value[7:0], select_active[8], accepted[9], zero fill up to 15
    output logic [lwcs_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: has_byte[0], is_data[1]
    output logic [lwcs_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lwcs_pkg::APB_AW-1:0]    paddr,
    input  logic [lwcs_pkg::APB_DW-1:0]    pwdata,
    output logic [lwcs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    lwcs_pkg::cfg_t  cfg_reg;
    lwcs_pkg::cfg_t  cfg_next;
    lwcs_pkg::item_t item_reg;
    lwcs_pkg::job_t  job;
    logic            a_valid_reg;
    logic            a_valid_next;
    logic            window_open_reg;
    logic            window_open_next;
    logic            job_ready;
    logic            s_accept;
    logic            cfg_write;
    logic [1:0]      reg_idx;
    logic [lwcs_pkg::COORD_W-1:0] rd_word;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                lwcs_pkg::REG_SCREEN_WIDTH:  cfg_next.width  = pwdata[15:0];
                lwcs_pkg::REG_SCREEN_HEIGHT: cfg_next.height = pwdata[15:0];
                lwcs_pkg::REG_OFFSET_X:      cfg_next.off_x  = pwdata[15:0];
                lwcs_pkg::REG_OFFSET_Y:      cfg_next.off_y  = pwdata[15:0];
                default:                     cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lwcs_pkg::REG_SCREEN_WIDTH:  rd_word = cfg_reg.width;
            lwcs_pkg::REG_SCREEN_HEIGHT: rd_word = cfg_reg.height;
            lwcs_pkg::REG_OFFSET_X:      rd_word = cfg_reg.off_x;
            lwcs_pkg::REG_OFFSET_Y:      rd_word = cfg_reg.off_y;
            default:                     rd_word = '0;
        endcase
    end
    assign prdata = {16'd0, rd_word};

    // Request register: refills when empty or when the sequencer takes the held request.
    assign s_tready     = !a_valid_reg || job_ready;
    assign s_accept     = s_tvalid && s_tready;
    assign a_valid_next = s_accept ? 1'b1 : (job_ready ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func   <= s_tuser[2:0];
            item_reg.x      <= s_tdata[15:0];
            item_reg.y      <= s_tdata[31:16];
            item_reg.width  <= s_tdata[47:32];
            item_reg.height <= s_tdata[63:48];
            item_reg.color  <= s_tdata[79:64];
            item_reg.enable <= s_tdata[80];
        end
    end

    // Control state: registers, request valid and the open-window flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width   <= lwcs_pkg::RST_SCREEN_WIDTH;
            cfg_reg.height  <= lwcs_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.off_x   <= lwcs_pkg::RST_OFFSET_X;
            cfg_reg.off_y   <= lwcs_pkg::RST_OFFSET_Y;
            a_valid_reg     <= 1'b0;
            window_open_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            a_valid_reg <= a_valid_next;
            if (a_valid_reg && job_ready) begin
                window_open_reg <= window_open_next;
            end
        end
    end

    lwcs_decode u_decode (
        .cfg_item         (item_reg),
        .cfg              (cfg_reg),
        .window_open      (window_open_reg),
        .job              (job),
        .window_open_next (window_open_next)
    );

    lwcs_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (a_valid_reg),
        .job_ready (job_ready),
        .job       (job),
        .cfg       (cfg_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // A status-only result is always the single result of its request.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status result without last");

    // A byte that releases chip select ends its request.
    a_release_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tdata[8] |-> m_tlast)
        else $error("chip select released before the last byte");

    // A rejected request never carries a byte.
    a_reject_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> !m_tuser[0])
        else $error("rejected request produced a byte");

    // The window opens only when a decoded request is handed to the sequencer.
    a_open_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(window_open_reg) |-> $past(a_valid_reg && job_ready))
        else $error("window opened without a request transfer");
`endif

endmodule

// File: tb/sv/tb_lcd_window_command_serializer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lcd_window_command_serializer_top.
// Drives drawing requests and APB register writes, predicts the serial byte stream and
// checks every result transfer; depends on lwcs_pkg and the serializer RTL only.
module tb_lcd_window_command_serializer_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 8;

    // One serial result as seen on the master side.
    typedef struct packed {
        logic [lwcs_pkg::BYTE_W-1:0] byte_value;
        logic                        has_byte;
        logic                        is_data;
        logic                        select_active;
        logic                        accepted;
        logic                        last;
    } serial_out_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic [lwcs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [lwcs_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lwcs_pkg::M_TDATA_W-1:0] m_tdata;
    logic [lwcs_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [lwcs_pkg::APB_AW-1:0]    paddr = '0;
    logic [lwcs_pkg::APB_DW-1:0]    pwdata = '0;
    logic [lwcs_pkg::APB_DW-1:0]    prdata;
    logic                           pready;

    // Testbench copy of the panel registers and the window state.
    logic [lwcs_pkg::COORD_W-1:0] cfg_width  = lwcs_pkg::RST_SCREEN_WIDTH;
    logic [lwcs_pkg::COORD_W-1:0] cfg_height = lwcs_pkg::RST_SCREEN_HEIGHT;
    logic [lwcs_pkg::COORD_W-1:0] cfg_off_x  = lwcs_pkg::RST_OFFSET_X;
    logic [lwcs_pkg::COORD_W-1:0] cfg_off_y  = lwcs_pkg::RST_OFFSET_Y;
    logic                         win_open   = 1'b0;

    lwcs_pkg::item_t pend_reqs[$];
    serial_out_t     due_bytes[$];
    lwcs_pkg::item_t cur_req;

    int  fail_count   = 0;
    int  reqs_queued  = 0;
    int  reqs_sent    = 0;
    int  results_seen = 0;
    int  settings_run = 1;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  calm_left    = 0;
    int  hold_left    = 0;
    int  ready_left   = 0;
    bit  driver_busy  = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_served  = 1'b0;

    lcd_window_command_serializer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Random field values at the width of the request fields.
    function automatic logic [lwcs_pkg::COORD_W-1:0] rand_word();
        return 16'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    // Byte predictor: each helper appends expected results in output order.
    function automatic void add_byte(logic [lwcs_pkg::BYTE_W-1:0] b, logic data, logic sel,
                                     logic last);
        serial_out_t r;
        r.byte_value    = b;
        r.has_byte      = 1'b1;
        r.is_data       = data;
        r.select_active = sel;
        r.accepted      = 1'b1;
        r.last          = last;
        due_bytes.push_back(r);
    endfunction

    function automatic void add_status(logic acc);
        serial_out_t r;
        r               = '0;
        r.select_active = win_open;
        r.accepted      = acc;
        r.last          = 1'b1;
        due_bytes.push_back(r);
    endfunction

    // A 16-bit word goes out high byte first; sel_lo is the select level after the low byte.
    function automatic void add_word(logic [lwcs_pkg::COORD_W-1:0] v, logic sel_lo,
                                     logic last);
        add_byte(v[15:8], 1'b1, 1'b1, 1'b0);
        add_byte(v[7:0], 1'b1, sel_lo, last);
    endfunction

    // Offsets are added with 16-bit wraparound by the narrow arguments.
    function automatic void add_window(logic [lwcs_pkg::COORD_W-1:0] x1,
                                       logic [lwcs_pkg::COORD_W-1:0] y1,
                                       logic [lwcs_pkg::COORD_W-1:0] x2,
                                       logic [lwcs_pkg::COORD_W-1:0] y2,
                                       logic last);
        logic [lwcs_pkg::COORD_W-1:0] ax1, ay1, ax2, ay2;
        ax1 = x1 + cfg_off_x;
        ax2 = x2 + cfg_off_x;
        ay1 = y1 + cfg_off_y;
        ay2 = y2 + cfg_off_y;
        add_byte(lwcs_pkg::OP_COLSET, 1'b0, 1'b1, 1'b0);
        add_word(ax1, 1'b1, 1'b0);
        add_word(ax2, 1'b1, 1'b0);
        add_byte(lwcs_pkg::OP_ROWSET, 1'b0, 1'b1, 1'b0);
        add_word(ay1, 1'b1, 1'b0);
        add_word(ay2, 1'b1, 1'b0);
        add_byte(lwcs_pkg::OP_MEMWRITE, 1'b0, 1'b1, last);
    endfunction

    // Works out the serial results of one accepted request and updates the window state.
    function automatic void serialize_request(lwcs_pkg::item_t q);
        logic [lwcs_pkg::COORD_W:0] w, h;
        logic                       off_panel;
        w         = {1'b0, q.width};
        h         = {1'b0, q.height};
        off_panel = (q.x >= cfg_width) || (q.y >= cfg_height);
        case (q.func)
            lwcs_pkg::FUNC_PIXEL: begin
                if (off_panel) begin
                    add_status(1'b0);
                end else begin
                    add_window(q.x, q.y, q.x + 16'd1, q.y + 16'd1, 1'b0);
                    add_word(q.color, 1'b0, 1'b1);
                    win_open = 1'b0;
                end
            end
            lwcs_pkg::FUNC_CLIP, lwcs_pkg::FUNC_STRICT: begin
                if (off_panel) begin
                    add_status(1'b0);
                end else if (q.func == lwcs_pkg::FUNC_STRICT &&
                             ({1'b0, q.x} + w > {1'b0, cfg_width} ||
                              {1'b0, q.y} + h > {1'b0, cfg_height})) begin
                    add_status(1'b0);
                end else begin
                    if ({1'b0, q.x} + w > {1'b0, cfg_width}) w = {1'b0, cfg_width - q.x};
                    if ({1'b0, q.y} + h > {1'b0, cfg_height}) h = {1'b0, cfg_height - q.y};
                    // A zero size wraps the end corner to one before the start.
                    add_window(q.x, q.y, q.x + w[lwcs_pkg::COORD_W-1:0] - 16'd1,
                               q.y + h[lwcs_pkg::COORD_W-1:0] - 16'd1, 1'b1);
                    win_open = 1'b1;
                end
            end
            lwcs_pkg::FUNC_COLOR: begin
                if (!win_open) add_status(1'b0);
                else add_word(q.color, 1'b1, 1'b1);
            end
            lwcs_pkg::FUNC_CLOSE: begin
                win_open = 1'b0;
                add_status(1'b1);
            end
            lwcs_pkg::FUNC_INVERT: begin
                win_open = 1'b0;
                add_byte(q.enable ? lwcs_pkg::OP_INV_ON : lwcs_pkg::OP_INV_OFF,
                         1'b0, 1'b0, 1'b1);
            end
            default: begin
                add_status(1'b0);
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sender gap: mostly short, a few long, with stretches of back-to-back transfers.
    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 5) begin
            calm_left = $urandom_range(10, 20);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Request driver: holds each request until the block takes it.
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            driver_busy = 1'b0;
            send_gap    = 0;
        end else begin
            offer = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                serialize_request(cur_req);
                reqs_sent++;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_reqs.size() > 0) begin
                    cur_req  = pend_reqs.pop_front();
                    s_tdata  <= {7'b0, cur_req.enable, cur_req.color, cur_req.height,
                                 cur_req.width, cur_req.y, cur_req.x};
                    s_tuser  <= cur_req.func;
                    offer    = 1'b1;
                    send_gap = pick_send_gap();
                end
            end
            s_tvalid    <= offer;
            driver_busy = offer;
        end
    end

    // Result backpressure, including one long hold-off on request.
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(1, 20);
            end else if (r < 55) begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(40, 80);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(10, 30);
            end
        end
    end

    // Result checker: compares each transfer with the oldest expected result.
    always @(posedge aclk) begin
        serial_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tuser[0], m_tuser[1], m_tdata[8], m_tdata[9], m_tlast};
            results_seen++;
            if (due_bytes.size() == 0) begin
                $error("Result transfer with nothing expected: byte %0h", got.byte_value);
                fail_count++;
            end else begin
                want = due_bytes.pop_front();
                check_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
                check_field("has_byte", 32'(want.has_byte), 32'(got.has_byte));
                check_field("is_data", 32'(want.is_data), 32'(got.is_data));
                check_field("select_active", 32'(want.select_active),
                            32'(got.select_active));
                check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", idle_cycles);
            $display("lcd_window_command_serializer_top test failed");
            $finish;
        end
    end

    task automatic push_req(logic [lwcs_pkg::FUNC_W-1:0] f, logic [lwcs_pkg::COORD_W-1:0] x,
                            logic [lwcs_pkg::COORD_W-1:0] y,
                            logic [lwcs_pkg::COORD_W-1:0] w,
                            logic [lwcs_pkg::COORD_W-1:0] h,
                            logic [lwcs_pkg::COORD_W-1:0] c, logic en);
        lwcs_pkg::item_t q;
        q.func   = f;
        q.x      = x;
        q.y      = y;
        q.width  = w;
        q.height = h;
        q.color  = c;
        q.enable = en;
        pend_reqs.push_back(q);
        reqs_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [lwcs_pkg::COORD_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lwcs_pkg::REG_SCREEN_WIDTH:  cfg_width  = val;
            lwcs_pkg::REG_SCREEN_HEIGHT: cfg_height = val;
            lwcs_pkg::REG_OFFSET_X:      cfg_off_x  = val;
            default:                     cfg_off_y  = val;
        endcase
    endtask

    task automatic set_panel(logic [lwcs_pkg::COORD_W-1:0] w, logic [lwcs_pkg::COORD_W-1:0] h,
                             logic [lwcs_pkg::COORD_W-1:0] ox,
                             logic [lwcs_pkg::COORD_W-1:0] oy);
        write_reg(lwcs_pkg::REG_SCREEN_WIDTH, w);
        write_reg(lwcs_pkg::REG_SCREEN_HEIGHT, h);
        write_reg(lwcs_pkg::REG_OFFSET_X, ox);
        write_reg(lwcs_pkg::REG_OFFSET_Y, oy);
        settings_run++;
    endtask

    // Waits until the sender is drained and every expected result has arrived.
    task automatic wait_idle();
        while (pend_reqs.size() > 0 || driver_busy || due_bytes.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Coordinate mostly on the panel, sometimes its last position, sometimes anywhere.
    function automatic logic [lwcs_pkg::COORD_W-1:0] in_span(
        logic [lwcs_pkg::COORD_W-1:0] limit);
        if (limit == 0 || $urandom_range(0, 9) == 0) return rand_word();
        if ($urandom_range(0, 9) == 0) return limit - 16'd1;
        return 16'($urandom_range(0, limit - 1));
    endfunction

    task automatic queue_directed();
        // Pixels at both corners, off each edge, and at the far end of the range.
        push_req(lwcs_pkg::FUNC_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 1'b0);
        push_req(lwcs_pkg::FUNC_PIXEL, 16'd127, 16'd159, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        push_req(lwcs_pkg::FUNC_PIXEL, 16'd128, 16'd0, 16'd1, 16'd1, 16'h1234, 1'b0);
        push_req(lwcs_pkg::FUNC_PIXEL, 16'd0, 16'd160, 16'd1, 16'd1, 16'h1234, 1'b0);
        push_req(lwcs_pkg::FUNC_PIXEL, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'h1234, 1'b0);
        // Color with no window open is rejected.
        push_req(lwcs_pkg::FUNC_COLOR, 16'd0, 16'd0, 16'd0, 16'd0, 16'hBEEF, 1'b0);
        // Full-panel window, two colors, close.
        push_req(lwcs_pkg::FUNC_CLIP, 16'd0, 16'd0, 16'd128, 16'd160, 16'h0000, 1'b0);
        push_req(lwcs_pkg::FUNC_COLOR, 16'd0, 16'd0, 16'd0, 16'd0, 16'hA55A, 1'b0);
        push_req(lwcs_pkg::FUNC_COLOR, 16'd0, 16'd0, 16'd0, 16'd0, 16'h5AA5, 1'b0);
        push_req(lwcs_pkg::FUNC_CLOSE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        // Clipping at both edges, a zero size that wraps, and the largest size.
        push_req(lwcs_pkg::FUNC_CLIP, 16'd100, 16'd150, 16'd100, 16'd100, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_COLOR, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8001, 1'b0);
        push_req(lwcs_pkg::FUNC_CLIP, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_CLIP, 16'd10, 16'd20, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        // Strict windows: exact fit, too wide, too tall, off the panel.
        push_req(lwcs_pkg::FUNC_STRICT, 16'd0, 16'd0, 16'd128, 16'd160, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_STRICT, 16'd1, 16'd0, 16'd128, 16'd10, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_STRICT, 16'd0, 16'd1, 16'd10, 16'd160, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_STRICT, 16'd200, 16'd0, 16'd1, 16'd1, 16'd0, 1'b0);
        // Invert both ways closes the open window; close with nothing open.
        push_req(lwcs_pkg::FUNC_INVERT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_req(lwcs_pkg::FUNC_INVERT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        push_req(lwcs_pkg::FUNC_CLOSE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        // Unused function codes are rejected.
        push_req(3'd6, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
        push_req(3'd7, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
    endtask

    // Random requests with random content; window and color runs are the most common kind.
    task automatic queue_random(int n);
        int                           stop_at, pick;
        logic [lwcs_pkg::COORD_W-1:0] x, y, w, h;
        stop_at = reqs_queued + n;
        while (reqs_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            x    = in_span(cfg_width);
            y    = in_span(cfg_height);
            if (pick < 35) begin
                if ($urandom_range(0, 1)) begin
                    w = (x < cfg_width) ? 16'($urandom_range(0, cfg_width - x)) : rand_word();
                    h = (y < cfg_height) ? 16'($urandom_range(0, cfg_height - y))
                                         : rand_word();
                    push_req(lwcs_pkg::FUNC_STRICT, x, y, w, h, rand_word(), rand_bit());
                end else begin
                    w = $urandom_range(0, 1) ? rand_word() : 16'($urandom_range(0, cfg_width));
                    h = $urandom_range(0, 1) ? rand_word()
                                             : 16'($urandom_range(0, cfg_height));
                    push_req(lwcs_pkg::FUNC_CLIP, x, y, w, h, rand_word(), rand_bit());
                end
                repeat ($urandom_range(1, 6))
                    push_req(lwcs_pkg::FUNC_COLOR, rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word(), rand_bit());
                case ($urandom_range(0, 3))
                    0, 1: push_req(lwcs_pkg::FUNC_CLOSE, rand_word(), rand_word(),
                                   rand_word(), rand_word(), rand_word(), rand_bit());
                    2: push_req(lwcs_pkg::FUNC_INVERT, rand_word(), rand_word(),
                                rand_word(), rand_word(), rand_word(), rand_bit());
                    default: ;
                endcase
            end else if (pick < 60) begin
                push_req(lwcs_pkg::FUNC_PIXEL, x, y, rand_word(), rand_word(), rand_word(),
                         rand_bit());
            end else if (pick < 70) begin
                push_req(lwcs_pkg::FUNC_COLOR, x, y, rand_word(), rand_word(), rand_word(),
                         rand_bit());
            end else if (pick < 78) begin
                push_req(lwcs_pkg::FUNC_INVERT, rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_bit());
            end else if (pick < 84) begin
                push_req(lwcs_pkg::FUNC_CLOSE, rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_bit());
            end else if (pick < 92) begin
                push_req($urandom_range(0, 1) ? lwcs_pkg::FUNC_CLIP : lwcs_pkg::FUNC_STRICT,
                         rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_bit());
            end else begin
                push_req(3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_bit());
            end
        end
    endtask

    // Test sequence: reset, then one phase per register setting.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults after reset.
        queue_directed();
        wait_idle();

        // Small panel with offsets that wrap the coordinates.
        set_panel(16'd16, 16'd12, 16'hFFF0, 16'hFFFF);
        queue_random(20);
        wait_idle();

        // Largest panel.
        set_panel(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_random(16);
        wait_idle();

        // Single-pixel panel.
        set_panel(16'd1, 16'd1, 16'h8000, 16'h7FFF);
        queue_random(10);
        wait_idle();

        // Zero-sized panel rejects every position.
        set_panel(16'd0, 16'd0, 16'd3, 16'd4);
        queue_random(6);
        wait_idle();

        // Random panel while the receiver holds off for a long stretch.
        set_panel(16'($urandom_range(40, 300)), 16'($urandom_range(40, 300)), rand_word(),
                  rand_word());
        hold_request = 1'b1;
        queue_random(20);
        wait_idle();

        // Back to the reset values.
        set_panel(lwcs_pkg::RST_SCREEN_WIDTH, lwcs_pkg::RST_SCREEN_HEIGHT,
                  lwcs_pkg::RST_OFFSET_X, lwcs_pkg::RST_OFFSET_Y);
        queue_random(14);
        wait_idle();

        if (due_bytes.size() != 0) begin
            $error("%0d expected results never arrived", due_bytes.size());
            fail_count++;
        end
        $display("Sent %0d drawing requests over %0d panel settings, checked %0d results.",
                 reqs_sent, settings_run, results_seen);
        $display("Covered pixels, clipped and strict windows, colors, close, invert, bad codes.");
        if (fail_count == 0) begin
            $display("lcd_window_command_serializer_top test passed");
        end else begin
            $display("lcd_window_command_serializer_top test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lwcs_pkg.sv
design/lwcs_decode.sv
design/lwcs_emit.sv
design/lcd_window_command_serializer_top.sv
tb/sv/tb_lcd_window_command_serializer_top.sv
